@@ rtl/isl_pkg.sv @@
// Shared types and constants for the indexed sequence list.
// Operation and status codes, store sizing, and the controller command struct.
`default_nettype none

package isl_pkg;

  // Store sizing.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed widths of the word fields.
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  // Common width for comparing a position against the element count.
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD_FRONT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAKE_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ       = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input word into the operand registers
    logic exec;  // perform the held operation and load the result registers
  } isl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/isl_ctrl.sv @@
// Controller for the indexed sequence list: input and output handshakes.
// Depends on isl_pkg for the command struct.
`default_nettype none

module isl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output isl_pkg::isl_cmd_t cmd
);
  import isl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // The result register is free when empty or being taken this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  // Take a word only while idle; run it once the result register is free.
  always_comb begin
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid is set by an executed word and cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  // An accepted word always moves the controller to the execute state.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted word did not move to execute");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // Execution always produces a visible result.
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("execute did not raise result valid");
`endif

endmodule

`default_nettype wire

@@ rtl/isl_dp.sv @@
// Datapath for the indexed sequence list: operand registers, the shifting
// chain of entries, the element count and the result registers. Uses isl_pkg.
`default_nettype none

module isl_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isl_pkg::isl_cmd_t                   cmd,
  input  logic [isl_pkg::OP_W-1:0]            in_operation,
  input  logic [isl_pkg::POS_W-1:0]           in_position,
  input  logic signed [isl_pkg::WORD_W-1:0]   in_word_in,
  output logic [isl_pkg::STAT_W-1:0]          out_status,
  output logic signed [isl_pkg::WORD_W-1:0]   out_word_out,
  output logic [isl_pkg::COUNT_W-1:0]         out_count
);
  import isl_pkg::*;

  // Operand registers.
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;

  // Entry chain, front at entry 0, and the element count.
  logic [WORD_W-1:0] elem_r   [CAPACITY];
  logic [WORD_W-1:0] elem_nxt [CAPACITY];
  logic [CNT_W-1:0]  occ_r, occ_nxt;

  // Result registers.
  logic [STAT_W-1:0] status_r;
  logic [WORD_W-1:0] rd_r;
  logic [CNT_W-1:0]  count_r;

  logic [STAT_W-1:0] status_c;
  logic [WORD_W-1:0] rd_c;
  logic              place_c;
  logic              remove_c;
  logic [IDX_W-1:0]  idx_c;
  logic [CMP_W-1:0]  pos_cmp;
  logic [CMP_W-1:0]  occ_cmp;
  logic              full_c;
  logic              empty_c;

  assign pos_cmp = CMP_W'(pos_r);
  assign occ_cmp = CMP_W'(occ_r);
  assign full_c  = (occ_r == CNT_W'(CAPACITY));
  assign empty_c = (occ_r == '0);

  // Decode the operation into a place, a remove, or a read at one index.
  always_comb begin
    status_c = ST_DONE;
    rd_c     = '0;
    place_c  = 1'b0;
    remove_c = 1'b0;
    idx_c    = IDX_W'(pos_r);
    unique case (op_r) inside
      OP_ADD_FRONT, OP_ADD_BACK: begin
        idx_c = (op_r == OP_ADD_FRONT) ? '0 : IDX_W'(occ_r);
        if (full_c) begin
          status_c = ST_FULL;
        end else begin
          place_c = 1'b1;
        end
      end
      OP_TAKE_FRONT, OP_TAKE_BACK: begin
        idx_c = (op_r == OP_TAKE_FRONT) ? '0 : IDX_W'(occ_r - CNT_W'(1));
        if (empty_c) begin
          status_c = ST_IGNORED;
        end else begin
          remove_c = 1'b1;
        end
      end
      OP_INSERT: begin
        // The range check comes before the full check.
        if (pos_cmp > occ_cmp) begin
          status_c = ST_IGNORED;
        end else if (full_c) begin
          status_c = ST_FULL;
        end else begin
          place_c = 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos_cmp >= occ_cmp) begin
          status_c = ST_IGNORED;
        end else begin
          remove_c = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_cmp >= occ_cmp) begin
          status_c = ST_IGNORED;
        end else begin
          rd_c = elem_r[idx_c];
        end
      end
      default: status_c = ST_IGNORED;
    endcase
  end

  // On a place the cells past the index, on a remove the cells from the index on,
  // take their neighbor's word in parallel; entries past the count hold nothing of value, so they shift freely.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      elem_nxt[i] = elem_r[i];
    end
    if (place_c) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (IDX_W'(i) > idx_c) begin
          elem_nxt[i] = elem_r[i-1];
        end
      end
      elem_nxt[idx_c] = word_r;
    end else if (remove_c) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (IDX_W'(i) >= idx_c) begin
          elem_nxt[i] = elem_r[i+1];
        end
      end
    end
  end

  // Count moves by one on a place or a remove.
  always_comb begin
    occ_nxt = occ_r;
    if (place_c) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (remove_c) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  // Payload registers: operands, entries and results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        elem_r[i] <= elem_nxt[i];
      end
      status_r <= status_c;
      rd_r     <= rd_c;
      count_r  <= occ_nxt;
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.exec) begin
      occ_r <= occ_nxt;
    end
  end

  assign out_status   = status_r;
  assign out_word_out = rd_r;
  assign out_count    = COUNT_W'(count_r);

`ifndef SYNTH
  // The count never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // The count changes only when an operation executes.
  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(occ_r))
    else $error("element count changed without an operation");

  // The count moves by at most one per operation.
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (occ_r == $past(occ_r) || occ_r == $past(occ_r) + CNT_W'(1) ||
                  occ_r == $past(occ_r) - CNT_W'(1)))
    else $error("element count jumped");
`endif

endmodule

`default_nettype wire

@@ rtl/indexed_sequence_list_top.sv @@
// Top level of the indexed sequence list: controller and datapath.
// Depends on isl_pkg, isl_ctrl and isl_dp.
`default_nettype none

// The block holds an ordered sequence of up to 16 signed 32-bit words and
// takes one operation per input word: push or pop at either end, insert or
// erase at a position, or read at a position. Each operation returns exactly
// one result word with a status (done, ignored, or full), the word read, and
// the element count afterward. An operation first captures the input word
// into the operand registers; then the whole chain of entries shifts in
// parallel and the result register is loaded. A new word is accepted only
// once the last one has executed; a waiting result holds off execution of
// the next word, not its acceptance. The entry store needs no clearing after
// reset.

module indexed_sequence_list_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [isl_pkg::OP_W-1:0]            in_operation,
  input  logic [isl_pkg::POS_W-1:0]           in_position,
  input  logic signed [isl_pkg::WORD_W-1:0]   in_word_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [isl_pkg::STAT_W-1:0]          out_status,
  output logic signed [isl_pkg::WORD_W-1:0]   out_word_out,
  output logic [isl_pkg::COUNT_W-1:0]         out_count
);
  import isl_pkg::*;

  isl_cmd_t cmd;

  // Handshake control.
  isl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Entry chain and result registers.
  isl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_status   (out_status),
    .out_word_out (out_word_out),
    .out_count    (out_count)
  );

endmodule

`default_nettype wire
